[src/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and opcodes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_NEG = 4'd4, OP_INC = 4'd5, OP_DEC = 4'd6, OP_EQ = 4'd7,
    OP_NE = 4'd8, OP_LT = 4'd9, OP_GT = 4'd10, OP_GE = 4'd11,
    OP_LE = 4'd12, OP_RED = 4'd13, OP_RSV14 = 4'd14, OP_RSV15 = 4'd15
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_FIN, ST_GCD_CHK, ST_DIV, ST_GCD_STEP,
    ST_QDIV, ST_QDIV2, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word
    logic mul1;      // first product pair
    logic mul2;      // second product pair
    logic fin;       // form arithmetic / compare result
    logic div_start; // start shared divider
    logic div_step;  // one restoring step
    logic gcd_swap;  // x <= y, y <= remainder
    logic q_start_n; // divide a_num mag by gcd
    logic q_start_d; // divide a_den by gcd
    logic q_take_n;  // latch numerator quotient
    logic red_fin;   // form reduce result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic     mult_op;  // op needs products
    logic     red_op;   // reduce op
    logic     red_ok;   // denominator positive
    logic     y_zero;   // gcd remainder is zero
    logic     div_done; // divider finished
  } sts_t;

endpackage

[src/rau_if.sv]
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels for operand and result words.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source(output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [31:0] res_den;
  logic        cmp_true;
  modport source(output valid, res_num, res_den, cmp_true, input ready);
  modport sink(input valid, res_num, res_den, cmp_true, output ready);
endinterface

[src/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for products, Euclid loop and output handshake.
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;
  logic   qn_phase_r, qn_phase_nxt; // 1: numerator quotient phase, 0: otherwise
  logic   qd_phase_r, qd_phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      qn_phase_r <= 1'b0;
      qd_phase_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      qn_phase_r <= qn_phase_nxt;
      qd_phase_r <= qd_phase_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    qn_phase_nxt = qn_phase_r;
    qd_phase_nxt = qd_phase_r;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (sts.red_op) begin
          cmd.red_fin = 1'b1;  // default: unchanged
          state_nxt   = sts.red_ok ? ST_GCD_CHK : ST_OUT;
        end else if (sts.mult_op) begin
          cmd.mul1  = 1'b1;
          state_nxt = ST_MUL2;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_GCD_CHK: begin
        if (sts.y_zero) begin
          cmd.q_start_n = 1'b1;
          qn_phase_nxt  = 1'b1;
          state_nxt     = ST_QDIV;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_GCD_STEP;
      end
      ST_GCD_STEP: begin
        cmd.gcd_swap = 1'b1;
        state_nxt    = ST_GCD_CHK;
      end
      ST_QDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.q_take_n  = 1'b1;
          cmd.q_start_d = 1'b1;
          qn_phase_nxt  = 1'b0;
          qd_phase_nxt  = 1'b1;
          state_nxt     = ST_QDIV2;
        end
      end
      ST_QDIV2: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.red_fin  = 1'b1;
          qd_phase_nxt = 1'b0;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    qn_phase_r |-> state_r == ST_QDIV)
    else $error("numerator quotient phase out of place");
  assert property (@(posedge clk) disable iff (!rst_n)
    qd_phase_r |-> state_r == ST_QDIV2)
    else $error("denominator quotient phase out of place");

endmodule

[src/rau_dp.sv]
// ----------------------------------------------------------------------------
// rau_dp
// Operand registers, multipliers, restoring divider and result regs.
// ----------------------------------------------------------------------------
module rau_dp
  import rau_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic [3:0]  in_kind,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [31:0] res_num,
  output logic [31:0] res_den,
  output logic        cmp_true
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W + 1);

  op_t                 op_r;
  logic signed [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [2*W-1:0] p0_r, p1_r, p2_r, p3_r;
  logic [W-1:0]        gx_r, gy_r;
  logic [W-1:0]        dq_r, drem_r, ddiv_r;
  logic [CW-1:0]       dcnt_r;
  logic [W-1:0]        qn_r;
  logic [31:0]         rn_r, rd_r;
  logic                c_r;

  logic [W-1:0] a_mag;
  logic [W:0]   trial;
  logic [W-1:0] rem_sh;
  logic [W-1:0] q_next;
  logic signed [W-1:0] rn_w, rd_w;
  logic signed [2*W-1:0] lhs, rhs;

  assign a_mag  = an_r[W-1] ? W'(-an_r) : W'(an_r);
  assign rem_sh = {drem_r[W-2:0], dq_r[W-1]};
  assign trial  = {drem_r, dq_r[W-1]} - {1'b0, ddiv_r};
  assign q_next = {dq_r[W-2:0], !trial[W]};
  assign lhs    = p0_r;
  assign rhs    = p1_r;

  function automatic logic [31:0] sext(input logic [W-1:0] v);
    return 32'(signed'(v));
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_kind);
      an_r <= in_a_num[W-1:0];
      ad_r <= in_a_den[W-1:0];
      bn_r <= in_b_num[W-1:0];
      bd_r <= in_b_den[W-1:0];
      gx_r <= in_a_num[W-1] ? W'(-in_a_num[W-1:0]) : in_a_num[W-1:0];
      gy_r <= in_a_den[W-1:0];
    end
    // first pair: cross products; second pair: num/den products
    if (cmd.mul1) begin
      p0_r <= (2*W)'(an_r) * (2*W)'(bd_r);
      p1_r <= (2*W)'(bn_r) * (2*W)'(ad_r);
    end
    if (cmd.mul2) begin
      p2_r <= (2*W)'(an_r) * (2*W)'(bn_r);
      p3_r <= (2*W)'(ad_r) * (2*W)'(bd_r);
    end
    if (cmd.div_start) begin
      dq_r <= gx_r; drem_r <= '0; ddiv_r <= gy_r; dcnt_r <= CW'(W);
    end else if (cmd.q_start_n) begin
      dq_r <= a_mag; drem_r <= '0; ddiv_r <= gx_r; dcnt_r <= CW'(W);
    end else if (cmd.q_start_d) begin
      dq_r <= ad_r; drem_r <= '0; ddiv_r <= gx_r; dcnt_r <= CW'(W);
    end else if (cmd.div_step) begin
      if (!trial[W]) begin
        drem_r <= trial[W-1:0];
        dq_r   <= {dq_r[W-2:0], 1'b1};
      end else begin
        drem_r <= rem_sh;
        dq_r   <= {dq_r[W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.gcd_swap) begin
      gx_r <= gy_r;
      gy_r <= drem_r;
    end
    if (cmd.q_take_n) qn_r <= q_next;
    if (cmd.fin) begin
      rn_r <= sext(rn_w);
      rd_r <= sext(rd_w);
      case (op_r)
        OP_EQ: c_r <= lhs == rhs;
        OP_NE: c_r <= lhs != rhs;
        OP_LT: c_r <= lhs < rhs;
        OP_GT: c_r <= lhs > rhs;
        OP_GE: c_r <= lhs >= rhs;
        OP_LE: c_r <= lhs <= rhs;
        default: c_r <= 1'b0;
      endcase
    end
    if (cmd.red_fin) begin
      c_r <= 1'b0;
      if (cmd.div_step && gx_r != W'(1)) begin
        rn_r <= sext(an_r[W-1] ? W'(-qn_r) : qn_r);
        rd_r <= sext(q_next);
      end else if (!cmd.div_step) begin
        rn_r <= sext(an_r);
        rd_r <= sext(ad_r);
      end
    end
  end

  always_comb begin
    rn_w = '0;
    rd_w = '0;
    case (op_r)
      OP_ADD: begin rn_w = W'(p0_r + p1_r); rd_w = W'(p3_r); end
      OP_SUB: begin rn_w = W'(p0_r - p1_r); rd_w = W'(p3_r); end
      OP_MUL: begin rn_w = W'(p2_r); rd_w = W'(p3_r); end
      OP_DIV: begin rn_w = W'(p0_r); rd_w = W'(p1_r); end
      OP_NEG: begin rn_w = -an_r; rd_w = ad_r; end
      OP_INC: begin rn_w = an_r + ad_r; rd_w = ad_r; end
      OP_DEC: begin rn_w = an_r - ad_r; rd_w = ad_r; end
      default: begin rn_w = '0; rd_w = '0; end
    endcase
  end

  assign sts.mult_op  = (op_r == OP_ADD) || (op_r == OP_SUB) || (op_r == OP_MUL) ||
                        (op_r == OP_DIV) || (op_r == OP_EQ) || (op_r == OP_NE) ||
                        (op_r == OP_LT) || (op_r == OP_GT) || (op_r == OP_GE) ||
                        (op_r == OP_LE);
  assign sts.red_op   = op_r == OP_RED;
  assign sts.red_ok   = !ad_r[W-1] && (ad_r != '0);
  assign sts.y_zero   = gy_r == '0;
  assign sts.div_done = dcnt_r == CW'(1);

  assign res_num  = rn_r;
  assign res_den  = rd_r;
  assign cmp_true = c_r;

endmodule

[src/rational_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Fraction arithmetic, exact compare and gcd reduction.
// Add, sub, mul, div and compare ops step through MUL1, MUL2 and FIN to OUT;
//   neg, inc and dec skip MUL2; the result waits in OUT for out_ready.
// Reduce: each Euclid step runs the one-bit restoring divider, then a swap;
//   at a zero remainder it forms the numerator, then denominator quotients.
// One word in flight; next word accepted the cycle after the result is taken.
// Synchronous active-low reset returns the controller to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input logic clk,
  input logic rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk      (clk),
    .in_kind  (in_ch.kind),
    .in_a_num (in_ch.a_num),
    .in_a_den (in_ch.a_den),
    .in_b_num (in_ch.b_num),
    .in_b_den (in_ch.b_den),
    .cmd      (cmd),
    .sts      (sts),
    .res_num  (out_ch.res_num),
    .res_den  (out_ch.res_den),
    .cmp_true (out_ch.cmp_true)
  );

endmodule
